[rtl/cwag_pkg.sv]
// Shared constants, register codes and types for the window tap address generator.
package cwag_pkg;

    // Default parameter values
    localparam int MAX_FILTER_SIDE_DEF = 8;
    localparam int COORD_BITS_DEF      = 12;

    // Fixed field widths
    localparam int TAG_W      = 10;
    localparam int FIELD_W    = 12;
    localparam int SIDE_W     = 4;
    localparam int POS_W      = 22;
    localparam int SIZE_W     = 13;
    localparam int OFS_W      = 9;
    localparam int STEP_W     = 8;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // Decoupling queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_HEIGHT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_DIMS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_H     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_W     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDES      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DILATIONS    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FLIP_MODE    = 3'd7;

    // Decoded configuration seen by front and back
    typedef struct packed {
        logic [SIDE_W-1:0]       fh;
        logic [SIDE_W-1:0]       fw;
        logic signed [OFS_W-1:0] oh;
        logic signed [OFS_W-1:0] ow;
        logic [STEP_W-1:0]       sh;
        logic [STEP_W-1:0]       sw;
        logic [STEP_W-1:0]       dh;
        logic [STEP_W-1:0]       dw;
        logic [SIZE_W-1:0]       ih;
        logic [SIZE_W-1:0]       iw;
        logic                    flip;
    } cwag_cfg_t;

    // One queued output position with its first tap coordinates
    typedef struct packed {
        logic [TAG_W-1:0]        tag;
        logic signed [POS_W-1:0] row_start;
        logic signed [POS_W-1:0] col_start;
    } cwag_entry_t;

    // Back status toward the top level
    typedef struct packed {
        logic active;
        logic loading;
    } cwag_back_stat_t;

endpackage

[rtl/conv_window_tap_address_gen.sv]
// Top level: configuration registers, front end, queue and tap walker.
// With the queue empty and the walker idle, an accepted item passes through the queue, the
// walker registers and the result registers before its first result is strobed. Throughput:
// one result per cycle; an item holds the tap walker until all fh*fw taps are walked, and a two-entry
// queue lets the next items be accepted while the walker runs. The receiver cannot stall.
// Reset (rst_n low, asynchronous) empties the queue, stops the walker, restores registers.
module conv_window_tap_address_gen #(
    parameter int MAX_FILTER_SIDE = cwag_pkg::MAX_FILTER_SIDE_DEF,
    parameter int COORD_BITS      = cwag_pkg::COORD_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [cwag_pkg::TAG_W-1:0]       batch_index,
    input  logic [cwag_pkg::FIELD_W-1:0]     out_row,
    input  logic [cwag_pkg::FIELD_W-1:0]     out_col,
    input  logic                             cfg_we,
    input  logic [cwag_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cwag_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                             result_valid,
    output logic [cwag_pkg::TAG_W-1:0]       batch_tag,
    output logic [cwag_pkg::FIELD_W-1:0]     src_row,
    output logic [cwag_pkg::FIELD_W-1:0]     src_col,
    output logic                             is_pad,
    output logic                             last_tap
);
    import cwag_pkg::*;

    logic [SIZE_W-1:0]     input_height_reg;
    logic [SIZE_W-1:0]     input_width_reg;
    logic [11:0]           filter_dims_reg;
    logic [OFS_W-1:0]      offset_h_reg;
    logic [OFS_W-1:0]      offset_w_reg;
    logic [15:0]           strides_reg;
    logic [15:0]           dilations_reg;
    logic                  flip_mode_reg;

    logic [3:0]            fh_raw;
    logic [7:0]            fw_raw;
    cwag_cfg_t             cfg;
    logic                  push;
    cwag_entry_t           push_entry;
    cwag_entry_t           head;
    logic                  queue_empty;
    logic                  queue_full;
    logic                  pop;
    cwag_back_stat_t       back_stat;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_height_reg <= SIZE_W'(1);
            input_width_reg  <= SIZE_W'(1);
            filter_dims_reg  <= 12'h101;
            offset_h_reg     <= '0;
            offset_w_reg     <= '0;
            strides_reg      <= 16'h0101;
            dilations_reg    <= 16'h0101;
            flip_mode_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_INPUT_HEIGHT: input_height_reg <= cfg_data[SIZE_W-1:0];
                REG_INPUT_WIDTH:  input_width_reg  <= cfg_data[SIZE_W-1:0];
                REG_FILTER_DIMS:  filter_dims_reg  <= cfg_data[11:0];
                REG_OFFSET_H:     offset_h_reg     <= cfg_data[OFS_W-1:0];
                REG_OFFSET_W:     offset_w_reg     <= cfg_data[OFS_W-1:0];
                REG_STRIDES:      strides_reg      <= cfg_data;
                REG_DILATIONS:    dilations_reg    <= cfg_data;
                REG_FLIP_MODE:    flip_mode_reg    <= cfg_data[0];
                default:          flip_mode_reg    <= flip_mode_reg;
            endcase
        end
    end

    // Decode configuration, saturating filter sides into the supported range
    assign fh_raw = filter_dims_reg[11:8];
    assign fw_raw = filter_dims_reg[7:0];

    always_comb
    begin
        if (fh_raw == '0)
            cfg.fh = SIDE_W'(1);
        else if (32'(fh_raw) > MAX_FILTER_SIDE)
            cfg.fh = SIDE_W'(MAX_FILTER_SIDE);
        else
            cfg.fh = SIDE_W'(fh_raw);

        if (fw_raw == '0)
            cfg.fw = SIDE_W'(1);
        else if (32'(fw_raw) > MAX_FILTER_SIDE)
            cfg.fw = SIDE_W'(MAX_FILTER_SIDE);
        else
            cfg.fw = SIDE_W'(fw_raw);

        cfg.oh   = $signed(offset_h_reg);
        cfg.ow   = $signed(offset_w_reg);
        cfg.sh   = strides_reg[15:8];
        cfg.sw   = strides_reg[7:0];
        cfg.dh   = dilations_reg[15:8];
        cfg.dw   = dilations_reg[7:0];
        cfg.ih   = input_height_reg;
        cfg.iw   = input_width_reg;
        cfg.flip = flip_mode_reg;
    end

    assign busy = queue_full;

    cwag_front u_front (
        .start       (start),
        .queue_full  (queue_full),
        .batch_index (batch_index),
        .out_row     (out_row),
        .out_col     (out_col),
        .cfg         (cfg),
        .push        (push),
        .entry       (push_entry)
    );

    cwag_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (queue_empty),
        .full       (queue_full)
    );

    cwag_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .head         (head),
        .queue_empty  (queue_empty),
        .pop          (pop),
        .stat         (back_stat),
        .result_valid (result_valid),
        .batch_tag    (batch_tag),
        .src_row      (src_row),
        .src_col      (src_col),
        .is_pad       (is_pad),
        .last_tap     (last_tap)
    );

    // An item taken while everything is idle shows its first result after the queue, walker and result registers
    a_first_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !back_stat.active && queue_empty) |-> ##3 result_valid)
        else $error("first result of an item did not appear in time");

    // The walker only loads from a non-empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        back_stat.loading |-> !queue_empty)
        else $error("walker loaded from an empty queue");

    // Padded taps report zero coordinates
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && is_pad) |-> (src_row == '0 && src_col == '0))
        else $error("padded tap carries nonzero coordinates");

endmodule

[rtl/cwag_front.sv]
// Front end: accepts an output position and computes the coordinates of its first tap.
module cwag_front (
    input  logic                          start,
    input  logic                          queue_full,
    input  logic [cwag_pkg::TAG_W-1:0]    batch_index,
    input  logic [cwag_pkg::FIELD_W-1:0]  out_row,
    input  logic [cwag_pkg::FIELD_W-1:0]  out_col,
    input  cwag_pkg::cwag_cfg_t           cfg,
    output logic                          push,
    output cwag_pkg::cwag_entry_t         entry
);
    import cwag_pkg::*;

    localparam int PROD_W = FIELD_W + STEP_W;
    localparam int TAPOFS_W = SIDE_W + STEP_W;

    logic [PROD_W-1:0]   row_prod;
    logic [PROD_W-1:0]   col_prod;
    logic [SIDE_W-1:0]   fh_last;
    logic [SIDE_W-1:0]   fw_last;
    logic [TAPOFS_W-1:0] row_tap_ofs;
    logic [TAPOFS_W-1:0] col_tap_ofs;

    // Accept whenever the queue has room
    assign push = start && !queue_full;

    // Position times stride
    assign row_prod = PROD_W'(out_row) * PROD_W'(cfg.sh);
    assign col_prod = PROD_W'(out_col) * PROD_W'(cfg.sw);

    // In flip mode the walk starts at the far corner of the window
    assign fh_last     = cfg.fh - SIDE_W'(1);
    assign fw_last     = cfg.fw - SIDE_W'(1);
    assign row_tap_ofs = cfg.flip ? TAPOFS_W'(fh_last) * TAPOFS_W'(cfg.dh) : '0;
    assign col_tap_ofs = cfg.flip ? TAPOFS_W'(fw_last) * TAPOFS_W'(cfg.dw) : '0;

    // Form the first tap coordinates
    always_comb
    begin
        entry.tag       = batch_index;
        entry.row_start = POS_W'(cfg.oh)
                        + $signed(POS_W'(row_prod))
                        + $signed(POS_W'(row_tap_ofs));
        entry.col_start = POS_W'(cfg.ow)
                        + $signed(POS_W'(col_prod))
                        + $signed(POS_W'(col_tap_ofs));
    end

endmodule

[rtl/cwag_queue.sv]
// Short queue of output positions between the front and the tap walker.
module cwag_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  cwag_pkg::cwag_entry_t  push_entry,
    input  logic                   pop,
    output cwag_pkg::cwag_entry_t  head,
    output logic                   empty,
    output logic                   full
);
    import cwag_pkg::*;

    cwag_entry_t      mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign head  = mem[rd_ptr_reg];

    // Store pushed items
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    // Track fill level
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (PTR_W+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (PTR_W+1)'(1);
        end
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

[rtl/cwag_back.sv]
// Back end: walks the filter window one tap per cycle and registers each result.
module cwag_back #(
    parameter int COORD_BITS = cwag_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cwag_pkg::cwag_cfg_t           cfg,
    input  cwag_pkg::cwag_entry_t         head,
    input  logic                          queue_empty,
    output logic                          pop,
    output cwag_pkg::cwag_back_stat_t     stat,
    output logic                          result_valid,
    output logic [cwag_pkg::TAG_W-1:0]    batch_tag,
    output logic [cwag_pkg::FIELD_W-1:0]  src_row,
    output logic [cwag_pkg::FIELD_W-1:0]  src_col,
    output logic                          is_pad,
    output logic                          last_tap
);
    import cwag_pkg::*;

    localparam int MASK_BITS = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
    localparam logic [FIELD_W-1:0] CMASK = FIELD_W'((33'd1 << MASK_BITS) - 33'd1);

    logic                    active_reg;
    logic [TAG_W-1:0]        tag_reg;
    logic signed [POS_W-1:0] row_reg;
    logic signed [POS_W-1:0] col_reg;
    logic signed [POS_W-1:0] col_start_reg;
    logic [SIDE_W-1:0]       i_reg;
    logic [SIDE_W-1:0]       j_reg;

    logic signed [POS_W-1:0] dh_step;
    logic signed [POS_W-1:0] dw_step;
    logic                    row_end;
    logic                    tap_last;
    logic                    row_out;
    logic                    col_out;
    logic                    pad;

    logic                    valid_reg;
    logic [TAG_W-1:0]        tag_out_reg;
    logic [FIELD_W-1:0]      row_out_reg;
    logic [FIELD_W-1:0]      col_out_reg;
    logic                    pad_out_reg;
    logic                    last_out_reg;

    // Window position
    assign row_end  = (j_reg == cfg.fw - SIDE_W'(1));
    assign tap_last = row_end && (i_reg == cfg.fh - SIDE_W'(1));

    // Load a new item when idle or on the final tap of the current one
    assign pop = !queue_empty && (!active_reg || tap_last);

    assign stat.active  = active_reg;
    assign stat.loading = pop;

    // Signed tap steps
    assign dh_step = $signed(POS_W'(cfg.dh));
    assign dw_step = $signed(POS_W'(cfg.dw));

    // Classify the current tap against the image bounds
    assign row_out = row_reg[POS_W-1] || ((POS_W-1)'(row_reg) >= (POS_W-1)'(cfg.ih));
    assign col_out = col_reg[POS_W-1] || ((POS_W-1)'(col_reg) >= (POS_W-1)'(cfg.iw));
    assign pad     = row_out || col_out;

    // Walk taps row-major
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            i_reg      <= '0;
            j_reg      <= '0;
        end
        else
        begin
            if (pop)
            begin
                active_reg <= 1'b1;
                i_reg      <= '0;
                j_reg      <= '0;
            end
            else if (active_reg)
            begin
                if (tap_last)
                begin
                    active_reg <= 1'b0;
                end
                else if (row_end)
                begin
                    i_reg <= i_reg + SIDE_W'(1);
                    j_reg <= '0;
                end
                else
                begin
                    j_reg <= j_reg + SIDE_W'(1);
                end
            end
        end
    end

    // Advance tap coordinates
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            tag_reg       <= head.tag;
            row_reg       <= head.row_start;
            col_reg       <= head.col_start;
            col_start_reg <= head.col_start;
        end
        else if (active_reg)
        begin
            if (row_end)
            begin
                row_reg <= cfg.flip ? row_reg - dh_step : row_reg + dh_step;
                col_reg <= col_start_reg;
            end
            else
            begin
                col_reg <= cfg.flip ? col_reg - dw_step : col_reg + dw_step;
            end
        end
    end

    // Hold the result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= active_reg;
        end
    end

    // Register the result payload
    always_ff @(posedge clk)
    begin
        tag_out_reg  <= tag_reg;
        row_out_reg  <= pad ? '0 : (FIELD_W'(row_reg) & CMASK);
        col_out_reg  <= pad ? '0 : (FIELD_W'(col_reg) & CMASK);
        pad_out_reg  <= pad;
        last_out_reg <= tap_last;
    end

    assign result_valid = valid_reg;
    assign batch_tag    = tag_out_reg;
    assign src_row      = row_out_reg;
    assign src_col      = col_out_reg;
    assign is_pad       = pad_out_reg;
    assign last_tap     = last_out_reg && valid_reg;

endmodule

[bench/tap_scoreboard_pkg.sv]
// Tap record and expected-tap tracker for the window tap address generator bench.
package tap_scoreboard_pkg;

    import cwag_pkg::*;

    // One tap result as seen on the result ports
    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [FIELD_W-1:0] row;
        logic [FIELD_W-1:0] col;
        logic               pad;
        logic               last;
    } tap_t;

    class tap_scoreboard;
        tap_t                    expected_taps[$];
        int unsigned             mismatches;

        // Shadow of the block's configuration registers
        logic [SIZE_W-1:0]       height;
        logic [SIZE_W-1:0]       width;
        logic [11:0]             filter_dims;
        logic signed [OFS_W-1:0] ofs_h;
        logic signed [OFS_W-1:0] ofs_w;
        logic [CFG_DATA_W-1:0]   strides;
        logic [CFG_DATA_W-1:0]   dilations;
        logic                    flip;

        function new();
            mismatches  = 0;
            height      = 1;
            width       = 1;
            filter_dims = 12'h101;
            ofs_h       = '0;
            ofs_w       = '0;
            strides     = 16'h0101;
            dilations   = 16'h0101;
            flip        = 1'b0;
        endfunction

        // Mirror a register write seen on the configuration port
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_INPUT_HEIGHT: height      = data[SIZE_W-1:0];
                REG_INPUT_WIDTH:  width       = data[SIZE_W-1:0];
                REG_FILTER_DIMS:  filter_dims = data[11:0];
                REG_OFFSET_H:     ofs_h       = data[OFS_W-1:0];
                REG_OFFSET_W:     ofs_w       = data[OFS_W-1:0];
                REG_STRIDES:      strides     = data;
                REG_DILATIONS:    dilations   = data;
                REG_FLIP_MODE:    flip        = data[0];
                default:          ;
            endcase
        endfunction

        // Saturate a filter side into 1 .. 8
        function int clamp_side(int v);
            if (v < 1)
                return 1;
            if (v > MAX_FILTER_SIDE_DEF)
                return MAX_FILTER_SIDE_DEF;
            return v;
        endfunction

        // Expand one accepted output position into its expected taps
        function void note_position(logic [TAG_W-1:0] tag, logic [FIELD_W-1:0] orow,
                                    logic [FIELD_W-1:0] ocol);
            int     fh;
            int     fw;
            int     ki;
            int     kj;
            int     n;
            longint base_row;
            longint base_col;
            longint row;
            longint col;
            longint lim_h;
            longint lim_w;
            tap_t   t;
            fh       = clamp_side(int'(filter_dims[11:8]));
            fw       = clamp_side(int'(filter_dims[7:0]));
            base_row = longint'(ofs_h) + longint'(orow) * longint'(strides[15:8]);
            base_col = longint'(ofs_w) + longint'(ocol) * longint'(strides[7:0]);
            lim_h    = longint'(height);
            lim_w    = longint'(width);
            n        = 0;
            for (int i = 0; i < fh; i++)
            begin
                ki  = flip ? fh - 1 - i : i;
                row = base_row + longint'(ki) * longint'(dilations[15:8]);
                for (int j = 0; j < fw; j++)
                begin
                    kj     = flip ? fw - 1 - j : j;
                    col    = base_col + longint'(kj) * longint'(dilations[7:0]);
                    t.tag  = tag;
                    t.pad  = (row < 0) || (row >= lim_h) || (col < 0) || (col >= lim_w);
                    t.row  = t.pad ? '0 : FIELD_W'(row);
                    t.col  = t.pad ? '0 : FIELD_W'(col);
                    t.last = (n + 1 == fh * fw);
                    expected_taps.push_back(t);
                    n++;
                end
            end
        endfunction

        // Compare one strobed tap with the oldest expected tap
        function void check_tap(tap_t got);
            tap_t want;
            if (expected_taps.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected tap: tag=%0d row=%0d col=%0d pad=%0b last=%0b",
                             got.tag, got.row, got.col, got.pad, got.last);
                mismatches++;
                return;
            end
            want = expected_taps.pop_front();
            if (got.tag !== want.tag || got.row !== want.row || got.col !== want.col ||
                got.pad !== want.pad || got.last !== want.last)
            begin
                if (mismatches < 10)
                    $display("tap mismatch: want tag=%0d row=%0d col=%0d pad=%0b last=%0b, %s",
                             want.tag, want.row, want.col, want.pad, want.last,
                             $sformatf("got tag=%0d row=%0d col=%0d pad=%0b last=%0b",
                                       got.tag, got.row, got.col, got.pad, got.last));
                mismatches++;
            end
        endfunction
    endclass

endpackage

[bench/conv_window_tap_address_gen_test.sv]
// Self-checking bench for the window tap address generator: directed and random positions.
module conv_window_tap_address_gen_test;

    import cwag_pkg::*;
    import tap_scoreboard_pkg::*;

    localparam int NUM_REGS   = 2 ** CFG_IDX_W;
    localparam int CYCLE_CAP  = 200000;
    localparam int TAIL_WAIT  = 16;
    localparam int PER_CONFIG = 30;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  start       = 1'b0;
    logic [TAG_W-1:0]      batch_index = '0;
    logic [FIELD_W-1:0]    out_row     = '0;
    logic [FIELD_W-1:0]    out_col     = '0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  busy;
    logic                  result_valid;
    logic [TAG_W-1:0]      batch_tag;
    logic [FIELD_W-1:0]    src_row;
    logic [FIELD_W-1:0]    src_col;
    logic                  is_pad;
    logic                  last_tap;
    tap_t                  seen_tap;

    tap_scoreboard         taps;
    logic [CFG_DATA_W-1:0] reg_plan [NUM_REGS];
    int                    idle_pct;

    always #2 clk = ~clk;

    conv_window_tap_address_gen dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .batch_index  (batch_index),
        .out_row      (out_row),
        .out_col      (out_col),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .batch_tag    (batch_tag),
        .src_row      (src_row),
        .src_col      (src_col),
        .is_pad       (is_pad),
        .last_tap     (last_tap)
    );

    assign seen_tap = {batch_tag, src_row, src_col, is_pad, last_tap};

    // Track register writes, accepted items and strobed taps
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                taps.write_reg(cfg_index, cfg_data);
            if (start && !busy)
                taps.note_position(batch_index, out_row, out_col);
            if (result_valid)
                taps.check_tap(seen_tap);
        end
    end

    // Abort a hung run
    initial
    begin
        repeat (CYCLE_CAP) @(posedge clk);
        $display("FAILURE");
        $finish;
    end

    // Offer one item, idling first at random, and hold it until accepted
    task automatic send_item(logic [TAG_W-1:0] tag, logic [FIELD_W-1:0] r,
                             logic [FIELD_W-1:0] c);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start       <= 1'b1;
        batch_index <= tag;
        out_row     <= r;
        out_col     <= c;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    // Drop start and wait until every expected tap has arrived
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (taps.expected_taps.size() != 0)
            @(negedge clk);
    endtask

    // Drain, then write every register from the plan
    task automatic apply_plan();
        drain();
        for (int i = 0; i < NUM_REGS; i++)
        begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= reg_plan[i];
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_plan(int h, int w, int fd, int oh, int ow, int st, int dl, int fl);
        reg_plan[REG_INPUT_HEIGHT] = CFG_DATA_W'(h);
        reg_plan[REG_INPUT_WIDTH]  = CFG_DATA_W'(w);
        reg_plan[REG_FILTER_DIMS]  = CFG_DATA_W'(fd);
        reg_plan[REG_OFFSET_H]     = {{(CFG_DATA_W - OFS_W){1'b0}}, OFS_W'(oh)};
        reg_plan[REG_OFFSET_W]     = {{(CFG_DATA_W - OFS_W){1'b0}}, OFS_W'(ow)};
        reg_plan[REG_STRIDES]      = CFG_DATA_W'(st);
        reg_plan[REG_DILATIONS]    = CFG_DATA_W'(dl);
        reg_plan[REG_FLIP_MODE]    = CFG_DATA_W'(fl);
    endtask

    // Stride or dilation byte: mostly small, sometimes zero or anything
    function automatic int pick_step();
        int k;
        k = $urandom_range(7);
        if (k == 0)
            return 0;
        if (k == 1)
            return $urandom_range(255);
        return $urandom_range(1, 3);
    endfunction

    // Filter side: mostly 1..5, sometimes up to the max, zero or oversized
    function automatic int pick_side(int top);
        int k;
        k = $urandom_range(19);
        if (k == 0)
            return 0;
        if (k == 1)
            return $urandom_range(9, top);
        if (k < 5)
            return $urandom_range(6, 8);
        return $urandom_range(1, 5);
    endfunction

    // Image side: mostly small, sometimes zero, full range or oversized
    function automatic int pick_size();
        int k;
        k = $urandom_range(9);
        if (k == 0)
            return 0;
        if (k == 1)
            return $urandom_range(1, 4096);
        if (k == 2)
            return $urandom_range(4097, 8191);
        return $urandom_range(1, 48);
    endfunction

    function automatic int pick_offset();
        if ($urandom_range(4) == 0)
            return $urandom_range(511);
        return $urandom_range(6) - 3;
    endfunction

    task automatic plan_random_config();
        set_plan(pick_size(), pick_size(), (pick_side(15) << 8) | pick_side(255),
                 pick_offset(), pick_offset(), (pick_step() << 8) | pick_step(),
                 (pick_step() << 8) | pick_step(), $urandom_range(1));
    endtask

    // Position range that keeps most taps inside the image
    function automatic int near_span(logic [CFG_DATA_W-1:0] size, logic [7:0] step);
        int span;
        if (step == 0)
            return (1 << FIELD_W) - 1;
        span = int'(size) / int'(step) + 2;
        return (span > (1 << FIELD_W) - 1) ? (1 << FIELD_W) - 1 : span;
    endfunction

    task automatic send_random_item();
        logic [FIELD_W-1:0] r;
        logic [FIELD_W-1:0] c;
        if ($urandom_range(9) < 7)
        begin
            r = FIELD_W'($urandom_range(near_span(reg_plan[REG_INPUT_HEIGHT],
                                                  reg_plan[REG_STRIDES][15:8])));
            c = FIELD_W'($urandom_range(near_span(reg_plan[REG_INPUT_WIDTH],
                                                  reg_plan[REG_STRIDES][7:0])));
        end
        else
        begin
            r = FIELD_W'($urandom);
            c = FIELD_W'($urandom);
        end
        send_item(TAG_W'($urandom), r, c);
    endtask

    initial
    begin
        taps     = new();
        idle_pct = 28;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Reset configuration: 1x1 filter over a 1x1 image
        send_item(0, 0, 0);
        send_item(1023, 4095, 4095);
        send_item(5, 0, 1);

        // 3x3 window with one pixel of padding, corners and interior
        set_plan(16, 16, 12'h303, -1, -1, 16'h0101, 16'h0101, 0);
        apply_plan();
        send_item(1, 0, 0);
        send_item(2, 15, 15);
        send_item(3, 7, 8);
        send_item(4, 16, 0);

        // Largest window walked in reverse, with stride and dilation
        set_plan(40, 40, 12'h808, -2, -3, 16'h0202, 16'h0201, 1);
        apply_plan();
        send_item(6, 0, 0);
        send_item(7, 10, 12);
        send_item(8, 19, 19);

        // Extreme offsets on a full-size image, edge of the last row
        set_plan(4096, 4096, 12'h204, 255, -255, 16'h0101, 16'h0101, 0);
        apply_plan();
        send_item(9, 0, 300);
        send_item(10, 3840, 255);
        send_item(11, 4095, 4095);

        // Zero image height, zero filter sides, zero stride and dilation
        set_plan(0, 5, 12'h000, 0, 0, 16'h0000, 16'h0000, 1);
        apply_plan();
        send_item(12, 0, 0);
        send_item(13, 4095, 4095);

        // Oversized image so valid coordinates wrap, oversized filter sides
        set_plan(8191, 8191, 12'hFFF, -256, 255, 16'hFFFF, 16'h0000, 0);
        apply_plan();
        send_item(14, 20, 20);
        send_item(15, 4095, 0);
        send_item(16, 1, 31);

        // Maximum dilation with zero stride, reversed
        set_plan(8191, 8191, 12'h808, 0, 0, 16'h0000, 16'hFFFF, 1);
        apply_plan();
        send_item(17, 4095, 4095);

        // Random configurations under three sender idling profiles
        for (int p = 0; p < 9; p++)
        begin
            idle_pct = (p < 3) ? 28 : (p < 6) ? 73 : 0;
            plan_random_config();
            apply_plan();
            repeat (PER_CONFIG) send_random_item();
        end

        drain();
        repeat (TAIL_WAIT) @(negedge clk);
        if (taps.mismatches == 0 && taps.expected_taps.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
